/* hdl/plcr_pkg.sv */
// Shared types, widths and codes of the piecewise-linear color ramp.
package plcr_pkg;

    localparam int TABLE_LENGTH = 256;
    localparam int MAX_POINTS   = 16;

    localparam int REQ_W = 2;
    localparam int POS_W = 9;
    localparam int CH_W  = 8;
    localparam int RGB_W = 3 * CH_W;
    localparam int IDX_W = 8;
    localparam int STA_W = 2;
    localparam int NUM_W = 2 * CH_W;
    localparam int DEN_W = POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_COLOR = 2'd0,
        REQ_LOAD_ALPHA = 2'd1,
        REQ_CLEAR      = 2'd2,
        REQ_LOOKUP     = 2'd3
    } plcr_req_t;

    typedef enum logic [STA_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } plcr_status_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2,
        CH_ALPHA = 2'd3
    } plcr_chan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_CMP,
        S_INS_SHRD,
        S_INS_SHWR,
        S_LK_RD,
        S_LK_CMP,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } plcr_state_t;

    typedef struct packed {
        logic wr_en;
        logic cnt_inc;
        logic cnt_clr;
    } plcr_list_ctrl_t;

endpackage

/* hdl/plcr_req_if.sv */
// Request channel: valid, ready and the request fields.
interface plcr_req_if;
    import plcr_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] point_position;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
    logic [CH_W-1:0]  alpha_in;
    logic [IDX_W-1:0] entry_index;

    modport source (
        output valid, req_type, point_position, red_in, green_in, blue_in, alpha_in,
               entry_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, point_position, red_in, green_in, blue_in, alpha_in,
               entry_index,
        output ready
    );
endinterface

/* hdl/plcr_rsp_if.sv */
// Result channel: valid, ready and the result fields.
interface plcr_rsp_if;
    import plcr_pkg::*;

    logic             valid;
    logic             ready;
    logic [STA_W-1:0] status;
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [CH_W-1:0]  alpha_out;

    modport source (
        output valid, status, red_out, green_out, blue_out, alpha_out,
        input  ready
    );

    modport sink (
        input  valid, status, red_out, green_out, blue_out, alpha_out,
        output ready
    );
endinterface

/* hdl/plcr_list.sv */
// Control point list: position and value memory with a registered read port and a fill count.
module plcr_list #(
    parameter int DEPTH = plcr_pkg::MAX_POINTS,
    parameter int VAL_W = plcr_pkg::RGB_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  plcr_pkg::plcr_list_ctrl_t      ctrl,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [plcr_pkg::POS_W-1:0]     wr_pos,
    input  logic [VAL_W-1:0]               wr_val,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [plcr_pkg::POS_W-1:0]     rd_pos,
    output logic [VAL_W-1:0]               rd_val,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    import plcr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [POS_W-1:0] pos_mem [DEPTH];
    logic [VAL_W-1:0] val_mem [DEPTH];
    logic [POS_W-1:0] rd_pos_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            pos_mem[wr_addr] <= wr_pos;
            val_mem[wr_addr] <= wr_val;
        end
        rd_pos_reg <= pos_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_comb
    begin
        if (ctrl.cnt_clr)
            count_next = '0;
        else if (ctrl.cnt_inc)
            count_next = count_reg + CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign rd_pos = rd_pos_reg;
    assign rd_val = rd_val_reg;
    assign count  = count_reg;
endmodule

/* hdl/plcr_div.sv */
// Restoring divider: one quotient bit per cycle.
module plcr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [plcr_pkg::NUM_W-1:0] num,
    input  logic [plcr_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [plcr_pkg::NUM_W-1:0] quo
);
    import plcr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, den};
        fits      = !rem_sub[DEN_W];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

/* hdl/piecewise_linear_color_ramp.sv */
// Top level of the piecewise-linear color ramp: request sequencer, point lists and divider.
//
//   channel | modport | moves
//   --------+---------+----------------------------------------------
//   req     | sink    | load color, load alpha, clear or lookup request
//   rsp     | source  | status and interpolated RGBA, one per request
//
// One request at a time; req.ready is high only while the sequencer idles.
// Clear, full-list and empty-list requests go straight to the result. A load scans the stored
// points and moves the later ones up, each step waiting on the registered list memory read.
// A lookup scans the points in each list and, where the index falls between two points, runs
// the serial divider once for each channel of that list.
// Reset clears both fill counts; a result waits in its register while rsp stalls.
module piecewise_linear_color_ramp #(
    parameter int MAX_POINTS = plcr_pkg::MAX_POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    plcr_req_if.sink    req,
    plcr_rsp_if.source  rsp
);
    import plcr_pkg::*;

    localparam int PIDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    plcr_state_t      state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [PIDX_W-1:0] j_reg, j_next;
    logic             sel_reg, sel_next;
    plcr_chan_t       ch_reg, ch_next;
    plcr_status_t     status_reg, status_next;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [RGB_W-1:0] rgb_reg, rgb_next;
    logic [CH_W-1:0]  alpha_reg, alpha_next;
    logic [IDX_W-1:0] x_reg, x_next;

    logic [POS_W-1:0] prev_pos_reg, prev_pos_next;
    logic [RGB_W-1:0] prev_val_reg, prev_val_next;
    logic [POS_W-1:0] seg_p0_reg, seg_p0_next;
    logic [POS_W-1:0] seg_p1_reg, seg_p1_next;
    logic [RGB_W-1:0] seg_v0_reg, seg_v0_next;
    logic [RGB_W-1:0] seg_v1_reg, seg_v1_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [CH_W-1:0]  res_r_reg, res_r_next;
    logic [CH_W-1:0]  res_g_reg, res_g_next;
    logic [CH_W-1:0]  res_b_reg, res_b_next;
    logic [CH_W-1:0]  res_a_reg, res_a_next;

    logic             out_valid_reg, out_valid_next;
    logic [STA_W-1:0] out_status_reg, out_status_next;
    logic [CH_W-1:0]  out_r_reg, out_r_next;
    logic [CH_W-1:0]  out_g_reg, out_g_next;
    logic [CH_W-1:0]  out_b_reg, out_b_next;
    logic [CH_W-1:0]  out_a_reg, out_a_next;

    plcr_list_ctrl_t  c_ctrl, a_ctrl;
    logic [PIDX_W-1:0] rd_addr, wr_addr;
    logic [POS_W-1:0] wr_pos;
    logic [RGB_W-1:0] wr_val;
    logic [POS_W-1:0] c_rd_pos, a_rd_pos, rd_pos_sel;
    logic [RGB_W-1:0] c_rd_val, rd_val_sel;
    logic [CH_W-1:0]  a_rd_val;
    logic [CNT_W-1:0] c_count, a_count, cnt_sel;

    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    logic [POS_W-1:0] in_pos_sat;
    logic [CNT_W-1:0] in_cnt;
    logic             hold_en;
    logic [RGB_W-1:0] hold_val;
    logic [CH_W-1:0]  v0c, v1c, q8, ch_val, off, mag;
    logic [CH_W:0]    diff;

    plcr_list #(
        .DEPTH (MAX_POINTS),
        .VAL_W (RGB_W)
    ) u_color_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (c_ctrl),
        .wr_addr (wr_addr),
        .wr_pos  (wr_pos),
        .wr_val  (wr_val),
        .rd_addr (rd_addr),
        .rd_pos  (c_rd_pos),
        .rd_val  (c_rd_val),
        .count   (c_count)
    );

    plcr_list #(
        .DEPTH (MAX_POINTS),
        .VAL_W (CH_W)
    ) u_alpha_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (a_ctrl),
        .wr_addr (wr_addr),
        .wr_pos  (wr_pos),
        .wr_val  (wr_val[CH_W-1:0]),
        .rd_addr (rd_addr),
        .rd_pos  (a_rd_pos),
        .rd_val  (a_rd_val),
        .count   (a_count)
    );

    plcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign rd_pos_sel = sel_reg ? a_rd_pos : c_rd_pos;
    assign rd_val_sel = sel_reg ? {{(RGB_W-CH_W){1'b0}}, a_rd_val} : c_rd_val;
    assign cnt_sel    = sel_reg ? a_count : c_count;

    assign in_pos_sat = (req.point_position > POS_W'(TABLE_LENGTH)) ? POS_W'(TABLE_LENGTH)
                                                                     : req.point_position;
    assign in_cnt     = (plcr_req_t'(req.req_type) == REQ_LOAD_ALPHA) ? a_count : c_count;

    always_comb
    begin
        unique case (ch_reg)
            CH_RED:
            begin
                v0c = seg_v0_reg[3*CH_W-1:2*CH_W];
                v1c = seg_v1_reg[3*CH_W-1:2*CH_W];
            end
            CH_GREEN:
            begin
                v0c = seg_v0_reg[2*CH_W-1:CH_W];
                v1c = seg_v1_reg[2*CH_W-1:CH_W];
            end
            CH_BLUE, CH_ALPHA:
            begin
                v0c = seg_v0_reg[CH_W-1:0];
                v1c = seg_v1_reg[CH_W-1:0];
            end
            default:
            begin
                v0c = '0;
                v1c = '0;
            end
        endcase
        diff   = {1'b0, v1c} - {1'b0, v0c};
        mag    = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
        off    = x_reg - seg_p0_reg[CH_W-1:0];
        q8     = div_quo[CH_W-1:0];
        ch_val = neg_reg ? (v0c - q8) : (v0c + q8);
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        sel_next        = sel_reg;
        ch_next         = ch_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        rgb_next        = rgb_reg;
        alpha_next      = alpha_reg;
        x_next          = x_reg;
        prev_pos_next   = prev_pos_reg;
        prev_val_next   = prev_val_reg;
        seg_p0_next     = seg_p0_reg;
        seg_p1_next     = seg_p1_reg;
        seg_v0_next     = seg_v0_reg;
        seg_v1_next     = seg_v1_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        res_r_next      = res_r_reg;
        res_g_next      = res_g_reg;
        res_b_next      = res_b_reg;
        res_a_next      = res_a_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_r_next      = out_r_reg;
        out_g_next      = out_g_reg;
        out_b_next      = out_b_reg;
        out_a_next      = out_a_reg;
        c_ctrl          = '0;
        a_ctrl          = '0;
        rd_addr         = '0;
        wr_addr         = '0;
        wr_pos          = '0;
        wr_val          = '0;
        div_start       = 1'b0;
        hold_en         = 1'b0;
        hold_val        = '0;
        req.ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    pos_next    = in_pos_sat;
                    rgb_next    = {req.red_in, req.green_in, req.blue_in};
                    alpha_next  = req.alpha_in;
                    x_next      = req.entry_index;
                    k_next      = '0;
                    status_next = ST_OK;
                    res_r_next  = '0;
                    res_g_next  = '0;
                    res_b_next  = '0;
                    res_a_next  = '0;
                    unique case (plcr_req_t'(req.req_type))
                        REQ_LOAD_COLOR, REQ_LOAD_ALPHA:
                        begin
                            sel_next = (plcr_req_t'(req.req_type) == REQ_LOAD_ALPHA);
                            if (in_cnt >= CNT_W'(MAX_POINTS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                                state_next = S_INS_SCAN;
                        end
                        REQ_CLEAR:
                        begin
                            c_ctrl.cnt_clr = 1'b1;
                            a_ctrl.cnt_clr = 1'b1;
                            state_next     = S_DONE;
                        end
                        REQ_LOOKUP:
                        begin
                            sel_next = 1'b0;
                            if (c_count == '0 || a_count == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                                state_next = S_LK_RD;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            S_INS_SCAN:
            begin
                if (k_reg == cnt_sel)
                begin
                    j_next     = cnt_sel[PIDX_W-1:0];
                    state_next = S_INS_SHRD;
                end
                else
                begin
                    rd_addr    = k_reg[PIDX_W-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                if (rd_pos_sel < pos_reg)
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_INS_SCAN;
                end
                else if (rd_pos_sel == pos_reg)
                begin
                    status_next = ST_DUP;
                    state_next  = S_DONE;
                end
                else
                begin
                    j_next     = cnt_sel[PIDX_W-1:0];
                    state_next = S_INS_SHRD;
                end
            end

            S_INS_SHRD:
            begin
                if (j_reg == k_reg[PIDX_W-1:0])
                begin
                    wr_addr = k_reg[PIDX_W-1:0];
                    wr_pos  = pos_reg;
                    wr_val  = sel_reg ? {{(RGB_W-CH_W){1'b0}}, alpha_reg} : rgb_reg;
                    if (sel_reg)
                    begin
                        a_ctrl.wr_en   = 1'b1;
                        a_ctrl.cnt_inc = 1'b1;
                    end
                    else
                    begin
                        c_ctrl.wr_en   = 1'b1;
                        c_ctrl.cnt_inc = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = j_reg - PIDX_W'(1);
                    state_next = S_INS_SHWR;
                end
            end

            S_INS_SHWR:
            begin
                wr_addr = j_reg;
                wr_pos  = rd_pos_sel;
                wr_val  = rd_val_sel;
                if (sel_reg)
                    a_ctrl.wr_en = 1'b1;
                else
                    c_ctrl.wr_en = 1'b1;
                j_next     = j_reg - PIDX_W'(1);
                state_next = S_INS_SHRD;
            end

            S_LK_RD:
            begin
                if (k_reg == cnt_sel)
                begin
                    hold_en  = 1'b1;
                    hold_val = prev_val_reg;
                end
                else
                begin
                    rd_addr    = k_reg[PIDX_W-1:0];
                    state_next = S_LK_CMP;
                end
            end

            S_LK_CMP:
            begin
                if (rd_pos_sel >= {1'b0, x_reg})
                begin
                    if (k_reg == '0 || rd_pos_sel == {1'b0, x_reg})
                    begin
                        hold_en  = 1'b1;
                        hold_val = rd_val_sel;
                    end
                    else
                    begin
                        seg_p0_next = prev_pos_reg;
                        seg_v0_next = prev_val_reg;
                        seg_p1_next = rd_pos_sel;
                        seg_v1_next = rd_val_sel;
                        ch_next     = sel_reg ? CH_ALPHA : CH_RED;
                        state_next  = S_MUL;
                    end
                end
                else
                begin
                    prev_pos_next = rd_pos_sel;
                    prev_val_next = rd_val_sel;
                    k_next        = k_reg + CNT_W'(1);
                    state_next    = S_LK_RD;
                end
            end

            S_MUL:
            begin
                num_next   = {{CH_W{1'b0}}, mag} * {{CH_W{1'b0}}, off};
                den_next   = seg_p1_reg - seg_p0_reg;
                neg_next   = diff[CH_W];
                state_next = S_DIV_GO;
            end

            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (ch_reg)
                        CH_RED:
                        begin
                            res_r_next = ch_val;
                            ch_next    = CH_GREEN;
                            state_next = S_MUL;
                        end
                        CH_GREEN:
                        begin
                            res_g_next = ch_val;
                            ch_next    = CH_BLUE;
                            state_next = S_MUL;
                        end
                        CH_BLUE:
                        begin
                            res_b_next = ch_val;
                            sel_next   = 1'b1;
                            k_next     = '0;
                            state_next = S_LK_RD;
                        end
                        CH_ALPHA:
                        begin
                            res_a_next = ch_val;
                            state_next = S_DONE;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            S_DONE:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_r_next      = res_r_reg;
                    out_g_next      = res_g_reg;
                    out_b_next      = res_b_reg;
                    out_a_next      = res_a_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        if (hold_en)
        begin
            if (!sel_reg)
            begin
                res_r_next = hold_val[3*CH_W-1:2*CH_W];
                res_g_next = hold_val[2*CH_W-1:CH_W];
                res_b_next = hold_val[CH_W-1:0];
                sel_next   = 1'b1;
                k_next     = '0;
                state_next = S_LK_RD;
            end
            else
            begin
                res_a_next = hold_val[CH_W-1:0];
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        j_reg          <= j_next;
        sel_reg        <= sel_next;
        ch_reg         <= ch_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        rgb_reg        <= rgb_next;
        alpha_reg      <= alpha_next;
        x_reg          <= x_next;
        prev_pos_reg   <= prev_pos_next;
        prev_val_reg   <= prev_val_next;
        seg_p0_reg     <= seg_p0_next;
        seg_p1_reg     <= seg_p1_next;
        seg_v0_reg     <= seg_v0_next;
        seg_v1_reg     <= seg_v1_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        neg_reg        <= neg_next;
        res_r_reg      <= res_r_next;
        res_g_reg      <= res_g_next;
        res_b_reg      <= res_b_next;
        res_a_reg      <= res_a_next;
        out_status_reg <= out_status_next;
        out_r_reg      <= out_r_next;
        out_g_reg      <= out_g_next;
        out_b_reg      <= out_b_next;
        out_a_reg      <= out_a_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.red_out   = out_r_reg;
    assign rsp.green_out = out_g_reg;
    assign rsp.blue_out  = out_b_reg;
    assign rsp.alpha_out = out_a_reg;
endmodule

/* sim/plcr_ramp_checker.sv */
`timescale 1ns / 100ps
// Checker of the color ramp: follows both point lists, predicts each result and compares it.
module plcr_ramp_checker
    import plcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    plcr_req_if         req,
    plcr_rsp_if         rsp,
    output int unsigned pending,
    output int unsigned fail_count
);

    localparam int COLOR_LIST   = 0;
    localparam int ALPHA_LIST   = 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        plcr_status_t    status;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } ramp_rgba_t;

    logic [POS_W-1:0] point_pos [2][MAX_POINTS];
    logic [RGB_W-1:0] point_val [2][MAX_POINTS];
    int               point_cnt [2];
    ramp_rgba_t       rgba_due [$];
    int unsigned      results_seen;
    int unsigned      mismatches;

    function automatic plcr_status_t insert_point(int lst, logic [POS_W-1:0] pos,
                                                  logic [RGB_W-1:0] val);
        int k;
        int j;
        k = 0;
        if (point_cnt[lst] >= MAX_POINTS)
            return ST_FULL;
        while (k < point_cnt[lst] && point_pos[lst][k] < pos)
            k++;
        if (k < point_cnt[lst] && point_pos[lst][k] == pos)
            return ST_DUP;
        for (j = point_cnt[lst]; j > k; j--)
        begin
            point_pos[lst][j] = point_pos[lst][j-1];
            point_val[lst][j] = point_val[lst][j-1];
        end
        point_pos[lst][k] = pos;
        point_val[lst][k] = val;
        point_cnt[lst]++;
        return ST_OK;
    endfunction

    function automatic logic [CH_W-1:0] channel_at(int lst, int shift, logic [IDX_W-1:0] x);
        int n;
        int lo;
        int hi;
        int v0;
        int v1;
        int p0;
        int p1;
        int xi;
        n  = point_cnt[lst];
        xi = int'(x);
        if (xi <= int'(point_pos[lst][0]))
        begin
            lo = 0;
            hi = 0;
        end
        else if (xi >= int'(point_pos[lst][n-1]))
        begin
            lo = n - 1;
            hi = n - 1;
        end
        else
        begin
            lo = 0;
            while (lo + 1 < n && int'(point_pos[lst][lo+1]) <= xi)
                lo++;
            hi = lo + 1;
        end
        v0 = int'(point_val[lst][lo] >> shift) & 255;
        v1 = int'(point_val[lst][hi] >> shift) & 255;
        p0 = int'(point_pos[lst][lo]);
        p1 = int'(point_pos[lst][hi]);
        if (p1 <= p0)
            return CH_W'(v0);
        return CH_W'(v0 + (v1 - v0) * (xi - p0) / (p1 - p0));
    endfunction

    function automatic ramp_rgba_t predict_rgba(plcr_req_t kind, logic [POS_W-1:0] pos,
                                                logic [RGB_W-1:0] rgb, logic [CH_W-1:0] alpha,
                                                logic [IDX_W-1:0] idx);
        ramp_rgba_t       res;
        logic [POS_W-1:0] p;
        res = '0;
        p   = (pos > TABLE_LENGTH) ? POS_W'(TABLE_LENGTH) : pos;
        case (kind)
            REQ_LOAD_COLOR: res.status = insert_point(COLOR_LIST, p, rgb);
            REQ_LOAD_ALPHA: res.status = insert_point(ALPHA_LIST, p, RGB_W'(alpha));
            REQ_CLEAR:
            begin
                point_cnt[COLOR_LIST] = 0;
                point_cnt[ALPHA_LIST] = 0;
            end
            default:
            begin
                if (point_cnt[COLOR_LIST] == 0 || point_cnt[ALPHA_LIST] == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.red   = channel_at(COLOR_LIST, 16, idx);
                    res.green = channel_at(COLOR_LIST, 8, idx);
                    res.blue  = channel_at(COLOR_LIST, 0, idx);
                    res.alpha = channel_at(ALPHA_LIST, 0, idx);
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ramp_rgba_t got;
        ramp_rgba_t want;
        if (!rst_n)
        begin
            rgba_due.delete();
            point_cnt[COLOR_LIST] = 0;
            point_cnt[ALPHA_LIST] = 0;
            results_seen = 0;
            mismatches   = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                rgba_due.insert(rgba_due.size(),
                                predict_rgba(plcr_req_t'(req.req_type), req.point_position,
                                             {req.red_in, req.green_in, req.blue_in},
                                             req.alpha_in, req.entry_index));
            if (rsp.valid && rsp.ready)
            begin
                got = '{plcr_status_t'(rsp.status), rsp.red_out, rsp.green_out,
                        rsp.blue_out, rsp.alpha_out};
                results_seen++;
                if (rgba_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: result %0d arrived with no request pending:",
                                 results_seen, " status %0d rgba %h", got.status,
                                 {got.red, got.green, got.blue, got.alpha});
                end
                else
                begin
                    want = rgba_due.pop_front();
                    if (got.status !== want.status || got.red !== want.red ||
                        got.green !== want.green || got.blue !== want.blue ||
                        got.alpha !== want.alpha)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("ERROR: result %0d: expected status %0d r %h g %h b %h a %h,",
                                     results_seen, want.status, want.red, want.green,
                                     want.blue, want.alpha,
                                     " got status %0d r %h g %h b %h a %h",
                                     got.status, got.red, got.green, got.blue, got.alpha);
                    end
                end
            end
            pending    <= rgba_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* sim/tb_piecewise_linear_color_ramp.sv */
`timescale 1ns / 100ps
// Testbench top of the color ramp: clock, reset, request and stall stimulus, and the verdict.
module tb_piecewise_linear_color_ramp;
    import plcr_pkg::*;

    localparam int TOTAL_REQUESTS = 1750;
    localparam int TAIL_CYCLES    = 200;

    logic        clk;
    logic        rst_n;
    logic        steady;
    int unsigned pending;
    int unsigned fail_count;
    int unsigned items_sent;

    plcr_req_if req_ch ();
    plcr_rsp_if rsp_ch ();

    piecewise_linear_color_ramp i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    plcr_ramp_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return POS_W'($urandom_range(257, 511));
        if (roll < 15)
            return '0;
        if (roll < 20)
            return POS_W'(TABLE_LENGTH);
        if (roll < 50)
            return POS_W'($urandom_range(0, 16) * 16);
        return POS_W'($urandom_range(0, TABLE_LENGTH));
    endfunction

    task automatic send_request(input plcr_req_t kind, input logic [POS_W-1:0] pos,
                                input logic [RGB_W-1:0] rgb, input logic [CH_W-1:0] alpha,
                                input logic [IDX_W-1:0] idx);
        int unsigned gap;
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.point_position <= pos;
        req_ch.red_in         <= rgb[23:16];
        req_ch.green_in       <= rgb[15:8];
        req_ch.blue_in        <= rgb[7:0];
        req_ch.alpha_in       <= alpha;
        req_ch.entry_index    <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        gap = steady ? 0 : idle_cycles();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : rsp_stalls
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat (1 + $urandom_range(0, 15)) @(posedge clk);
            stall = steady ? 0 : idle_cycles();
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned episode;
        int unsigned steps;
        int unsigned roll;
        plcr_req_t   kind;
        steady     = 1'b0;
        items_sent = 0;
        episode    = 0;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_LOAD_COLOR;
        req_ch.point_position <= '0;
        req_ch.red_in         <= '0;
        req_ch.green_in       <= '0;
        req_ch.blue_in        <= '0;
        req_ch.alpha_in       <= '0;
        req_ch.entry_index    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd0);
        send_request(REQ_LOAD_COLOR, '0,     24'h000000, '0,   '0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd10);
        send_request(REQ_LOAD_ALPHA, 9'h1FF, '0,        8'hFF, '0);
        send_request(REQ_LOAD_ALPHA, 9'd256, '0,        8'h00, '0);
        send_request(REQ_LOAD_COLOR, 9'd300, 24'hFFFFFF, '0,   '0);
        send_request(REQ_LOAD_COLOR, '0,     24'h123456, '0,   '0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd255);
        send_request(REQ_LOAD_COLOR, 9'd64,  24'hFF8000, '0,   '0);
        send_request(REQ_LOAD_ALPHA, '0,     '0,        8'h80, '0);
        send_request(REQ_LOAD_ALPHA, 9'd100, '0,        8'h00, '0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd50);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd100);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd127);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd200);
        send_request(REQ_CLEAR,      '0,     '0,        '0,    '0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd128);
        send_request(REQ_LOAD_ALPHA, 9'd128, '0,        8'h7F, '0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd128);
        send_request(REQ_LOAD_COLOR, 9'd128, 24'hA5C33C, '0,   '0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd0);
        send_request(REQ_LOOKUP,     '0,     '0,        '0,    8'd255);

        while (items_sent < TOTAL_REQUESTS)
        begin
            steady = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 9) != 0)
                    send_request(REQ_CLEAR, pick_position(), RGB_W'($urandom),
                                 CH_W'($urandom), IDX_W'($urandom));
                steps = $urandom_range(8, 60);
                repeat (steps)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 33)
                        kind = REQ_LOAD_COLOR;
                    else if (roll < 63)
                        kind = REQ_LOAD_ALPHA;
                    else
                        kind = REQ_LOOKUP;
                    send_request(kind, pick_position(), RGB_W'($urandom), CH_W'($urandom),
                                 IDX_W'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(3, 12))
                    send_request(plcr_req_t'(REQ_W'($urandom_range(0, 3))), POS_W'($urandom),
                                 RGB_W'($urandom), CH_W'($urandom), IDX_W'($urandom));
            end
            if (episode % 6 == 2)
                drain_results();
            episode++;
        end

        steady = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/plcr_pkg.sv
hdl/plcr_req_if.sv
hdl/plcr_rsp_if.sv
hdl/plcr_list.sv
hdl/plcr_div.sv
hdl/piecewise_linear_color_ramp.sv
sim/plcr_ramp_checker.sv
sim/tb_piecewise_linear_color_ramp.sv
